// ----- hw/rtl/tpta_pkg.sv -----
// Shared types, widths, codes and tables for the two-plane track angle block.
package tpta_pkg;

  localparam int CMD_W     = 2;
  localparam int POS_W     = 16;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W     = 37;
  localparam int MAX_EVENTS = 1048576;
  localparam int CNT_W     = $clog2(MAX_EVENTS + 1);
  localparam int MEAN_W    = 18;
  localparam int XC_W      = 19;
  localparam int OUT_XC_W  = 17;
  localparam int TERM_W    = 20;
  localparam int PROD_W    = 2 * TERM_W;
  localparam int SQSUM_W   = 36;
  localparam int ROOT_W    = 26;
  localparam int SQIN_W    = 2 * ROOT_W;
  localparam int KMAG_W    = 32;
  localparam int DIVD_W    = 42;
  localparam int DIVS_W    = 26;
  localparam int QUO_W     = 18;
  localparam int COR_W     = 38;
  localparam int ANG_W     = 16;
  localparam int COS_W     = 16;
  localparam int COR_STEPS = 15;
  localparam int TILT_Q15  = 23170;

  localparam logic [CFG_W-1:0] LATERAL_OFFSET_RST = CFG_W'(1088);
  localparam logic [CFG_W-1:0] PLANE_GAP_RST      = CFG_W'(2176);

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACCUM   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CORRECT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_GAP      = 1'b1;

  localparam logic [2:0] MUL_LAST = 3'd5;
  localparam logic [ANG_W-1:0] ANG_HALF = 16'h8000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_CENTRE,
    ST_TERMS,
    ST_MUL,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_COS_GO,
    ST_COS_WAIT,
    ST_FINISH
  } tpta_state_t;

  function automatic logic [ANG_W-1:0] atan_lut(input logic [3:0] i);
    logic [ANG_W-1:0] r;
    case (i)
      4'd0:    r = 16'd8192;
      4'd1:    r = 16'd4836;
      4'd2:    r = 16'd2555;
      4'd3:    r = 16'd1297;
      4'd4:    r = 16'd651;
      4'd5:    r = 16'd326;
      4'd6:    r = 16'd163;
      4'd7:    r = 16'd81;
      4'd8:    r = 16'd41;
      4'd9:    r = 16'd20;
      4'd10:   r = 16'd10;
      4'd11:   r = 16'd5;
      4'd12:   r = 16'd3;
      4'd13:   r = 16'd1;
      4'd14:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [OUT_XC_W-1:0] sat_xc(input logic signed [XC_W-1:0] v);
    logic signed [OUT_XC_W-1:0] r;
    if (v[XC_W-1:OUT_XC_W-1] == '0 || v[XC_W-1:OUT_XC_W-1] == '1) begin
      r = v[OUT_XC_W-1:0];
    end else if (v[XC_W-1]) begin
      r = {1'b1, {(OUT_XC_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_XC_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/tpta_if.sv -----
// Valid/ready channels for hit beats and result beats.
interface tpta_hit_if;
  import tpta_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [POS_W-1:0] x_first;
  logic signed [POS_W-1:0] y_first;
  logic signed [POS_W-1:0] x_second;
  logic signed [POS_W-1:0] y_second;
  modport source (output valid, command, x_first, y_first, x_second, y_second, input ready);
  modport sink (input valid, command, x_first, y_first, x_second, y_second, output ready);
endinterface

interface tpta_res_if;
  import tpta_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_XC_W-1:0] x_first_centred;
  logic signed [OUT_XC_W-1:0] y_first_centred;
  logic signed [OUT_XC_W-1:0] x_second_centred;
  logic signed [OUT_XC_W-1:0] y_second_centred;
  logic signed [COS_W-1:0]    cos_polar;
  logic signed [ANG_W-1:0]    azimuth;
  logic                       empty_set;
  modport source (output valid, x_first_centred, y_first_centred, x_second_centred,
                  y_second_centred, cos_polar, azimuth, empty_set, input ready);
  modport sink (input valid, x_first_centred, y_first_centred, x_second_centred,
                y_second_centred, cos_polar, azimuth, empty_set, output ready);
endinterface

// ----- hw/rtl/tpta_div.sv -----
// Shared radix-2 restoring divider, one quotient bit per cycle.
module tpta_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tpta_pkg::DIVD_W-1:0]   dividend,
  input  logic [tpta_pkg::DIVS_W-1:0]   divisor,
  output logic                          busy,
  output logic [tpta_pkg::QUO_W-1:0]    quotient
);
  import tpta_pkg::*;

  localparam int DSH_W = DIVS_W + QUO_W - 1;

  logic [DIVD_W-1:0] rem;
  logic [DSH_W-1:0]  dsh;
  logic [4:0]        step;
  logic              ge;

  assign ge = DSH_W'(rem) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      rem      <= dividend;
      dsh      <= {divisor, {(QUO_W-1){1'b0}}};
      quotient <= '0;
      step     <= '0;
      busy     <= 1'b1;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh[DIVD_W-1:0];
      end
      quotient <= {quotient[QUO_W-2:0], ge};
      dsh      <= dsh >> 1;
      step     <= step + 5'd1;
      if (step == 5'(QUO_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/tpta_sqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per cycle.
module tpta_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tpta_pkg::SQIN_W-1:0]   radicand,
  output logic                          busy,
  output logic [tpta_pkg::ROOT_W-1:0]   root
);
  import tpta_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem;
  logic [SQIN_W-1:0] nsh;
  logic [4:0]        step;
  logic [REM_W-1:0]  rem2;
  logic [REM_W-1:0]  trial;

  assign rem2  = {rem[REM_W-3:0], nsh[SQIN_W-1:SQIN_W-2]};
  assign trial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      rem  <= '0;
      root <= '0;
      nsh  <= radicand;
      step <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (rem2 >= trial) begin
        rem  <= rem2 - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem2;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
      nsh  <= nsh << 2;
      step <= step + 5'd1;
      if (step == 5'(ROOT_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/tpta_cordic.sv -----
// Vectoring CORDIC for the azimuth, one micro-rotation per cycle.
module tpta_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [tpta_pkg::COR_W-1:0] x0,
  input  logic signed [tpta_pkg::COR_W-1:0] y0,
  output logic                              busy,
  output logic [tpta_pkg::ANG_W-1:0]        angle
);
  import tpta_pkg::*;

  logic signed [COR_W-1:0] x;
  logic signed [COR_W-1:0] y;
  logic signed [COR_W-1:0] xs;
  logic signed [COR_W-1:0] ys;
  logic [3:0]              step;

  assign xs = x >>> step;
  assign ys = y >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      step <= '0;
      if (x0 == '0 && y0 == '0) begin
        angle <= '0;
        busy  <= 1'b0;
      end else if (x0 < 0) begin
        x     <= -x0;
        y     <= -y0;
        angle <= ANG_HALF;
        busy  <= 1'b1;
      end else begin
        x     <= x0;
        y     <= y0;
        angle <= '0;
        busy  <= 1'b1;
      end
    end else if (busy) begin
      if (!y[COR_W-1]) begin
        x     <= x + ys;
        y     <= y - xs;
        angle <= angle + atan_lut(step);
      end else begin
        x     <= x - ys;
        y     <= y + xs;
        angle <= angle - atan_lut(step);
      end
      step <= step + 4'd1;
      if (step == 4'(COR_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/two_plane_track_angle.sv -----
// Track angle from two-plane hits: running means, centring, cosine and azimuth.
// A correct beat runs four mean quotients on the shared divider (skipped when no
// events are held), then the 26-step root, then one cosine quotient; CORDIC overlaps the root.
// One beat is in work at a time; the result waits in an output register.
// Synchronous reset restores register defaults and clears the sums and count.
module two_plane_track_angle (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tpta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpta_pkg::CFG_W-1:0]       cfg_data,
  tpta_hit_if.sink                         hits,
  tpta_res_if.source                       result
);
  import tpta_pkg::*;

  tpta_state_t state, state_next;

  logic [CFG_W-1:0]         lateral_offset;
  logic [CFG_W-1:0]         plane_gap;
  logic signed [SUM_W-1:0]  sums [4];
  logic [CNT_W-1:0]         event_count;
  logic signed [POS_W-1:0]  pos [4];
  logic signed [MEAN_W-1:0] mean [4];
  logic signed [XC_W-1:0]   xc [4];
  logic [1:0]               idx;
  logic [2:0]               mstep;
  logic signed [TERM_W-1:0] a_t;
  logic signed [TERM_W-1:0] v_t;
  logic signed [TERM_W-1:0] s_t;
  logic signed [TERM_W-1:0] gma_t;
  logic signed [PROD_W-1:0] prod;
  logic [SQSUM_W-1:0]       sumsq;
  logic [KMAG_W-1:0]        kmag;
  logic signed [COR_W-1:0]  cx0;
  logic                     out_valid;

  logic                     div_start, sq_start, cor_start;
  logic                     div_busy, sq_busy, cor_busy;
  logic [DIVD_W-1:0]        div_dividend;
  logic [DIVS_W-1:0]        div_divisor;
  logic [QUO_W-1:0]         quotient;
  logic [ROOT_W-1:0]        root;
  logic [ANG_W-1:0]         angle;

  logic signed [SUM_W-1:0]  sum_sel;
  logic [SUM_W-2:0]         sum_mag;
  logic signed [TERM_W-1:0] a_c;
  logic signed [TERM_W-1:0] gap_t;
  logic signed [TERM_W-1:0] s_abs;
  logic signed [TERM_W-1:0] opa, opb;
  logic signed [MEAN_W-1:0] q_mean;
  logic signed [COS_W-1:0]  cos_val;
  logic signed [COR_W-1:0]  cy0;

  assign hits.ready = (state == ST_IDLE);

  assign sum_sel = sums[idx];
  assign sum_mag = sum_sel[SUM_W-1] ? (SUM_W-1)'(-sum_sel) : sum_sel[SUM_W-2:0];
  assign q_mean  = $signed({1'b0, quotient[MEAN_W-2:0]});
  assign gap_t   = $signed(TERM_W'(plane_gap));
  assign a_c     = TERM_W'(xc[0]) - TERM_W'(xc[2]) + gap_t;
  assign s_abs   = s_t[TERM_W-1] ? -s_t : s_t;
  assign cy0     = COR_W'(v_t) <<< 15;

  always_comb begin
    if (state == ST_COS_GO) begin
      div_dividend = DIVD_W'({kmag, 8'b0}) + DIVD_W'(root >> 1);
      div_divisor  = root;
    end else begin
      div_dividend = DIVD_W'(sum_mag) + DIVD_W'(event_count >> 1);
      div_divisor  = DIVS_W'(event_count);
    end
  end

  always_comb begin
    case (mstep)
      3'd0:    begin opa = a_t;   opb = a_t;   end
      3'd1:    begin opa = v_t;   opb = v_t;   end
      3'd2:    begin opa = gap_t; opb = gap_t; end
      3'd3:    begin opa = s_abs; opb = TERM_W'(TILT_Q15); end
      default: begin opa = gma_t; opb = TERM_W'(TILT_Q15); end
    endcase
  end

  always_comb begin
    if (root == '0) begin
      cos_val = '0;
    end else if (s_t[TERM_W-1]) begin
      cos_val = (quotient > QUO_W'(32768)) ? COS_W'(-32768) : COS_W'(-$signed({1'b0, quotient}));
    end else begin
      cos_val = (quotient > QUO_W'(32767)) ? COS_W'(32767) : COS_W'(quotient);
    end
  end

  tpta_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  tpta_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand ({sumsq, 16'b0}),
    .busy     (sq_busy),
    .root     (root)
  );

  tpta_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .x0    (cx0),
    .y0    (cy0),
    .busy  (cor_busy),
    .angle (angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    sq_start   = 1'b0;
    cor_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (hits.valid && hits.command == CMD_CORRECT) begin
          state_next = (event_count == '0) ? ST_CENTRE : ST_MEAN_GO;
        end
      end
      ST_MEAN_GO: begin
        div_start  = 1'b1;
        state_next = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (!div_busy) begin
          state_next = (idx == 2'd3) ? ST_CENTRE : ST_MEAN_GO;
        end
      end
      ST_CENTRE: state_next = ST_TERMS;
      ST_TERMS:  state_next = ST_MUL;
      ST_MUL: begin
        if (mstep == MUL_LAST) begin
          state_next = ST_ROOT_GO;
        end
      end
      ST_ROOT_GO: begin
        sq_start   = 1'b1;
        cor_start  = 1'b1;
        state_next = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (!sq_busy) begin
          state_next = ST_COS_GO;
        end
      end
      ST_COS_GO: begin
        div_start  = 1'b1;
        state_next = ST_COS_WAIT;
      end
      ST_COS_WAIT: begin
        if (!div_busy && !cor_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lateral_offset <= LATERAL_OFFSET_RST;
      plane_gap      <= PLANE_GAP_RST;
      for (int i = 0; i < 4; i++) begin
        sums[i] <= '0;
      end
      event_count <= '0;
      out_valid   <= 1'b0;
      idx         <= '0;
      mstep       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LATERAL_OFFSET: lateral_offset <= cfg_data;
          CFG_PLANE_GAP:      plane_gap      <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_FINISH && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (hits.valid) begin
            unique case (hits.command)
              CMD_CLEAR: begin
                for (int i = 0; i < 4; i++) begin
                  sums[i] <= '0;
                end
                event_count <= '0;
              end
              CMD_ACCUM: begin
                if (event_count < CNT_W'(MAX_EVENTS)) begin
                  sums[0]     <= sums[0] + SUM_W'(hits.x_first);
                  sums[1]     <= sums[1] + SUM_W'(hits.y_first);
                  sums[2]     <= sums[2] + SUM_W'(hits.x_second);
                  sums[3]     <= sums[3] + SUM_W'(hits.y_second);
                  event_count <= event_count + CNT_W'(1);
                end
              end
              CMD_CORRECT: begin
                pos[0] <= hits.x_first;
                pos[1] <= hits.y_first;
                pos[2] <= hits.x_second;
                pos[3] <= hits.y_second;
                for (int i = 0; i < 4; i++) begin
                  mean[i] <= '0;
                end
                idx <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_MEAN_WAIT: begin
          if (!div_busy) begin
            mean[idx] <= sum_sel[SUM_W-1] ? -q_mean : q_mean;
            idx       <= idx + 2'd1;
          end
        end
        ST_CENTRE: begin
          xc[0] <= XC_W'(pos[0]) - XC_W'(mean[0]) - $signed(XC_W'(lateral_offset));
          xc[1] <= XC_W'(pos[1]) - XC_W'(mean[1]);
          xc[2] <= XC_W'(pos[2]) - XC_W'(mean[2]) + $signed(XC_W'(lateral_offset));
          xc[3] <= XC_W'(pos[3]) - XC_W'(mean[3]);
          mstep <= '0;
        end
        ST_TERMS: begin
          a_t   <= a_c;
          v_t   <= TERM_W'(xc[3]) - TERM_W'(xc[1]);
          s_t   <= a_c + gap_t;
          gma_t <= gap_t - a_c;
        end
        ST_MUL: begin
          prod  <= opa * opb;
          mstep <= mstep + 3'd1;
          case (mstep)
            3'd1:    sumsq <= prod[SQSUM_W-1:0];
            3'd2,
            3'd3:    sumsq <= sumsq + prod[SQSUM_W-1:0];
            3'd4:    kmag  <= prod[KMAG_W-1:0];
            3'd5:    cx0   <= COR_W'(prod);
            default: ;
          endcase
        end
        ST_FINISH: begin
          if (!out_valid || result.ready) begin
            result.x_first_centred  <= sat_xc(xc[0]);
            result.y_first_centred  <= sat_xc(xc[1]);
            result.x_second_centred <= sat_xc(xc[2]);
            result.y_second_centred <= sat_xc(xc[3]);
            result.cos_polar        <= cos_val;
            result.azimuth          <= angle;
            result.empty_set        <= (event_count == '0);
          end
        end
        default: ;
      endcase
    end
  end

  assign result.valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    event_count <= CNT_W'(MAX_EVENTS))
    else $error("event count beyond limit");

  a_units_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !div_busy && !sq_busy && !cor_busy)
    else $error("arithmetic unit busy while idle");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside finish");

  a_sums_hold: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |=> $stable(event_count))
    else $error("count changed during correction");

endmodule

// ----- verif/two_plane_track_angle_checker.sv -----
// Checker for the two-plane track angle block: predicts results and compares them.
module two_plane_track_angle_checker
  import tpta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  tpta_hit_if                  hits,
  tpta_res_if                  result,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    logic signed [OUT_XC_W-1:0] xc1;
    logic signed [OUT_XC_W-1:0] yc1;
    logic signed [OUT_XC_W-1:0] xc2;
    logic signed [OUT_XC_W-1:0] yc2;
    logic signed [COS_W-1:0]    cosp;
    logic signed [ANG_W-1:0]    azim;
    logic                       empty;
  } track_t;

  track_t track_q[$];
  logic [CFG_W-1:0] offset_r, gap_r;
  longint sum_x1, sum_y1, sum_x2, sum_y2;
  longint count;

  function automatic longint hit_mean(longint sum);
    longint unsigned mag, q;
    if (count == 0) return 0;
    mag = (sum < 0) ? -sum : sum;
    q = (mag + count / 2) / count;
    return (sum < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [OUT_XC_W-1:0] clip17(longint v);
    if (v > 65535) v = 65535;
    if (v < -65536) v = -65536;
    return v[OUT_XC_W-1:0];
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint z, xs, ys;
    longint steps[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 32768 : -32768;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 15; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += steps[i];
      end else begin
        x -= ys; y += xs; z -= steps[i];
      end
    end
    return z;
  endfunction

  function automatic track_t correct_track(longint x1, longint y1, longint x2, longint y2);
    track_t t;
    longint off, g, c1, d1, c2, d2, a, v, s, cv;
    longint unsigned r, mag, q;
    off = offset_r;
    g = gap_r;
    c1 = x1 - hit_mean(sum_x1) - off;
    d1 = y1 - hit_mean(sum_y1);
    c2 = x2 - hit_mean(sum_x2) + off;
    d2 = y2 - hit_mean(sum_y2);
    a = c1 - c2 + g;
    v = d2 - d1;
    r = root64(longint'(v * v + a * a + g * g) << 16);
    s = a + g;
    if (r == 0) begin
      cv = 0;
    end else begin
      mag = longint'((s < 0) ? -s : s) * TILT_Q15 * 256;
      q = (mag + r / 2) / r;
      if (s < 0) cv = (q > 32768) ? -32768 : -longint'(q);
      else cv = (q > 32767) ? 32767 : longint'(q);
    end
    t.xc1 = clip17(c1);
    t.yc1 = clip17(d1);
    t.xc2 = clip17(c2);
    t.yc2 = clip17(d2);
    t.cosp = cv[COS_W-1:0];
    t.azim = ANG_W'(cordic_angle(v * 32768, (g - a) * TILT_Q15));
    t.empty = (count == 0);
    return t;
  endfunction

  assign pending = track_q.size();

  always @(posedge clk) begin
    track_t got, want;
    if (rst) begin
      offset_r = LATERAL_OFFSET_RST;
      gap_r = PLANE_GAP_RST;
      sum_x1 = 0; sum_y1 = 0; sum_x2 = 0; sum_y2 = 0;
      count = 0;
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LATERAL_OFFSET) offset_r = cfg_data;
        else offset_r = offset_r;
        if (cfg_index == CFG_PLANE_GAP) gap_r = cfg_data;
      end
      if (result.valid && result.ready) begin
        got = '{result.x_first_centred, result.y_first_centred, result.x_second_centred,
                result.y_second_centred, result.cos_polar, result.azimuth, result.empty_set};
        if (track_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          errors <= errors + 1;
        end else begin
          want = track_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors <= errors + 1;
          end
        end
      end
      if (hits.valid && hits.ready) begin
        case (hits.command)
          CMD_CLEAR: begin
            sum_x1 = 0; sum_y1 = 0; sum_x2 = 0; sum_y2 = 0;
            count = 0;
          end
          CMD_ACCUM: begin
            if (count < MAX_EVENTS) begin
              sum_x1 += longint'(hits.x_first);
              sum_y1 += longint'(hits.y_first);
              sum_x2 += longint'(hits.x_second);
              sum_y2 += longint'(hits.y_second);
              count++;
            end
          end
          CMD_CORRECT: track_q.push_back(correct_track(longint'(hits.x_first),
            longint'(hits.y_first), longint'(hits.x_second), longint'(hits.y_second)));
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- verif/two_plane_track_angle_test.sv -----
// Stimulus and verdict for the two-plane track angle block.
module two_plane_track_angle_test;
  import tpta_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   errors, pending, sent;
  logic                 no_gaps, hold_req;

  tpta_hit_if hits ();
  tpta_res_if result ();

  two_plane_track_angle dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .hits(hits), .result(result)
  );

  two_plane_track_angle_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .hits(hits), .result(result), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random back-pressure, one long hold on request
  initial begin
    int gap;
    result.ready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (hold_req) begin
        gap = 400;
        hold_req = 0;
      end
      if (gap > 0) begin
        result.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      result.ready <= 1;
      do @(posedge clk); while (!(result.valid && result.ready));
    end
  end

  task automatic send(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] x1, logic [POS_W-1:0] y1,
                      logic [POS_W-1:0] x2, logic [POS_W-1:0] y2);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (!no_gaps && $urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      hits.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    hits.valid <= 1;
    hits.command <= cmd;
    hits.x_first <= x1;
    hits.y_first <= y1;
    hits.x_second <= x2;
    hits.y_second <= y2;
    do @(posedge clk); while (!(hits.valid && hits.ready));
    sent++;
  endtask

  task automatic settle;
    hits.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] any_pos();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] near(logic [POS_W-1:0] c);
    return c + POS_W'($urandom_range(0, 1023)) - POS_W'(512);
  endfunction

  // well-formed runs: an optional clear, a cluster of events, then corrections; some single random beats between
  task automatic run_block(int target);
    logic [POS_W-1:0] cx1, cy1, cx2, cy2;
    int n;
    while (sent < target) begin
      if ($urandom_range(0, 19) < 17) begin
        cx1 = any_pos(); cy1 = any_pos(); cx2 = any_pos(); cy2 = any_pos();
        if ($urandom_range(0, 2) != 0) send(CMD_CLEAR, any_pos(), any_pos(), any_pos(), any_pos());
        n = $urandom_range(0, 8);
        repeat (n) send(CMD_ACCUM, near(cx1), near(cy1), near(cx2), near(cy2));
        n = $urandom_range(1, 3);
        repeat (n) send(CMD_CORRECT, near(cx1), near(cy1), near(cx2), near(cy2));
      end else begin
        send(CMD_W'($urandom_range(0, 3)), any_pos(), any_pos(), any_pos(), any_pos());
      end
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = CFG_LATERAL_OFFSET;
    cfg_data = '0;
    hits.valid = 0;
    hits.command = CMD_CLEAR;
    hits.x_first = '0;
    hits.y_first = '0;
    hits.x_second = '0;
    hits.y_second = '0;
    sent = 0;
    no_gaps = 0;
    hold_req = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty set, extremes, overflow of centred values, unused command
    send(CMD_CORRECT, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send(CMD_CORRECT, 16'd2176, 16'd0, 16'd0, 16'd0);
    send(CMD_CORRECT, 16'd10000, 16'd5, 16'd0, 16'd5);
    send(CMD_CORRECT, 16'd0, 16'd0, 16'd0, 16'd0);
    send(CMD_ACCUM, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send(CMD_CORRECT, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send(CMD_ACCUM, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send(CMD_ACCUM, 16'd3, 16'hfffd, 16'd1, 16'hffff);
    send(CMD_CORRECT, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send(CMD_SPARE, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0);
    send(CMD_CORRECT, 16'd0, 16'd0, 16'd0, 16'd0);
    send(CMD_CLEAR, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send(CMD_CORRECT, 16'hffff, 16'h0001, 16'h0001, 16'hffff);
    settle();

    write_reg(CFG_LATERAL_OFFSET, 14'd16383);
    write_reg(CFG_PLANE_GAP, 14'd1);
    send(CMD_CORRECT, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send(CMD_CORRECT, 16'h7fff, 16'h0, 16'h8000, 16'h0);
    settle();
    sent = 0;

    write_reg(CFG_LATERAL_OFFSET, 14'd0);
    write_reg(CFG_PLANE_GAP, 14'd16383);
    hold_req = 1;
    run_block(300);
    settle();
    write_reg(CFG_LATERAL_OFFSET, LATERAL_OFFSET_RST);
    write_reg(CFG_PLANE_GAP, PLANE_GAP_RST);
    run_block(650);
    settle();
    write_reg(CFG_LATERAL_OFFSET, 14'd16383);
    write_reg(CFG_PLANE_GAP, 14'd16383);
    run_block(950);
    settle();
    write_reg(CFG_LATERAL_OFFSET, CFG_W'($urandom));
    write_reg(CFG_PLANE_GAP, CFG_W'($urandom_range(1, 16383)));
    run_block(1250);
    settle();

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
